[rtl/lfuc_pkg.sv]
package lfuc_pkg;

	localparam int unsigned DATA_BITS = 32;
	localparam int unsigned CAP_BITS  = 5;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	localparam logic [DATA_BITS-1:0] MISS_VALUE = '1;

	// controller to datapath
	typedef struct packed {
		logic start;     // capture transaction, clear scan results
		logic rd_en;     // issue a table read at the scan pointer
		logic commit;    // apply the update and latch the result
		logic load_out;  // move the result into the output register
	} lfuc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_addr; // scan pointer sits on the final entry
		logic out_busy;  // output register holds a result not yet taken
		logic out_ready; // downstream takes the result this cycle
	} lfuc_status_t;

endpackage

[rtl/lfu_cache_table.sv]
// LFU key-value cache. A get (tuser 0) looks up the key and returns the stored
// value, or -1 on a miss; a put (tuser 1) updates a present key or inserts a
// new one, evicting the entry with the lowest use count (oldest touch on a tie)
// when the live capacity is reached. Each transaction scans all ENTRIES table
// slots through one registered read port, one slot per cycle, then drains the
// read, commits the update and loads the result into the output register as
// soon as that register is free or its result is being taken. A new
// transaction is accepted once the previous result sits in the output register.
// cfg_wdata sets the live capacity (reset 16, zero ignores puts); write it only
// while the cache is idle.
module lfu_cache_table #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] lookup_key, [63:32] write_value
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic        m_tuser,   // [0] hit_found
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata  // live_capacity
);
	import lfuc_pkg::*;

	lfuc_cmd_t    cmd;
	lfuc_status_t status;
	logic         in_ready;

	// accept a transaction only while the controller is idle
	assign s_tready = in_ready;

	lfuc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lfuc_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.action      (s_tuser),
		.lookup_key  (s_tdata[31:0]),
		.write_value (s_tdata[63:32]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.hit_found   (m_tuser),
		.read_value  (m_tdata)
	);

endmodule

[rtl/lfuc_ctrl.sv]
module lfuc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lfuc_pkg::lfuc_status_t status,
	output lfuc_pkg::lfuc_cmd_t    cmd
);
	import lfuc_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_DRAIN   = 3'd2;
	localparam logic [2:0] ST_COMMIT  = 3'd3;
	localparam logic [2:0] ST_DELIVER = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_DELIVER;
			end
			ST_DELIVER: begin
				if (!status.out_busy || status.out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/lfuc_dp.sv]
module lfuc_dp #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lfuc_pkg::lfuc_cmd_t              cmd,
	output lfuc_pkg::lfuc_status_t           status,
	input  logic                             action,
	input  logic [lfuc_pkg::DATA_BITS-1:0]   lookup_key,
	input  logic [lfuc_pkg::DATA_BITS-1:0]   write_value,
	input  logic                             cfg_we,
	input  logic [lfuc_pkg::CAP_BITS-1:0]    cfg_wdata,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic                             hit_found,
	output logic [lfuc_pkg::DATA_BITS-1:0]   read_value
);
	import lfuc_pkg::*;

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = IW + 1;

	// table storage
	logic [DATA_BITS-1:0]  key_mem   [ENTRIES];
	logic [DATA_BITS-1:0]  val_mem   [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem   [ENTRIES];
	logic [63:0]           stamp_mem [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	logic [CAP_BITS-1:0]  live_cap_q;
	logic [CW-1:0]        cap_eff;
	logic [CW-1:0]        occ_q;
	logic [63:0]          clock_q;

	logic                 act_q;
	logic [DATA_BITS-1:0] key_q;
	logic [DATA_BITS-1:0] wval_q;

	logic [CW-1:0]        scan_q;
	logic [IW-1:0]        rd_addr;

	logic                  rd_valid_s1;
	logic [IW-1:0]         idx_s1;
	logic                  valid_s1;
	logic [DATA_BITS-1:0]  key_s1;
	logic [DATA_BITS-1:0]  val_s1;
	logic [COUNT_BITS-1:0] cnt_s1;
	logic [63:0]           stamp_s1;

	logic                  hit_q;
	logic [IW-1:0]         hit_idx_q;
	logic [DATA_BITS-1:0]  hit_val_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  free_q;
	logic [IW-1:0]         free_idx_q;
	logic                  vic_q;
	logic [IW-1:0]         vic_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [63:0]           vic_stamp_q;

	logic                  res_hit_q;
	logic [DATA_BITS-1:0]  res_val_q;

	logic                  is_put;
	logic                  cap_zero;
	logic                  use_free;
	logic                  do_bump;
	logic                  do_ins;
	logic                  wr_en;
	logic [IW-1:0]         wr_slot;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic                  better;

	assign rd_addr = scan_q[IW-1:0];
	assign cap_eff = (32'(live_cap_q) > 32'(ENTRIES)) ? CW'(ENTRIES) : CW'(live_cap_q);

	assign status.last_addr = (scan_q == CW'(ENTRIES - 1));
	assign status.out_busy  = out_valid;
	assign status.out_ready = out_ready;

	assign better = !vic_q || (cnt_s1 < vic_cnt_q) ||
		((cnt_s1 == vic_cnt_q) && (stamp_s1 < vic_stamp_q));

	assign is_put   = (act_q == ACT_PUT);
	assign cap_zero = (cap_eff == '0);
	assign use_free = free_q && (occ_q < cap_eff);
	assign do_bump  = hit_q && !(is_put && cap_zero);
	assign do_ins   = is_put && !cap_zero && !hit_q && (use_free || vic_q);
	assign wr_en    = cmd.commit && (do_bump || do_ins);
	assign wr_slot  = hit_q ? hit_idx_q : (use_free ? free_idx_q : vic_idx_q);
	assign wr_cnt   = do_bump ? ((&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + 1'b1)
	                          : COUNT_BITS'(1);

	// memories: one write port, registered read at the scan pointer
	always_ff @(posedge clk) begin
		if (wr_en && do_ins) begin
			key_mem[wr_slot] <= key_q;
		end
		if (wr_en && is_put) begin
			val_mem[wr_slot] <= wval_q;
		end
		if (wr_en) begin
			cnt_mem[wr_slot]   <= wr_cnt;
			stamp_mem[wr_slot] <= clock_q;
		end
		key_s1   <= key_mem[rd_addr];
		val_s1   <= val_mem[rd_addr];
		cnt_s1   <= cnt_mem[rd_addr];
		stamp_s1 <= stamp_mem[rd_addr];
		valid_s1 <= valid_q[rd_addr];
		idx_s1   <= rd_addr;
	end

	// transaction capture and scan accumulators
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q  <= action;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
		if (rd_valid_s1 && valid_s1 && (key_s1 == key_q) && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= val_s1;
			hit_cnt_q <= cnt_s1;
		end
		if (rd_valid_s1 && !valid_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (rd_valid_s1 && valid_s1 && better) begin
			vic_idx_q   <= idx_s1;
			vic_cnt_q   <= cnt_s1;
			vic_stamp_q <= stamp_s1;
		end
		if (cmd.commit) begin
			res_hit_q <= hit_q;
			res_val_q <= is_put ? '0 : (hit_q ? hit_val_q : MISS_VALUE);
		end
		if (cmd.load_out) begin
			hit_found  <= res_hit_q;
			read_value <= res_val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_cap_q  <= CAP_BITS'(16);
			valid_q     <= '0;
			occ_q       <= '0;
			clock_q     <= '0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			vic_q       <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				live_cap_q <= cfg_wdata;
			end
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.start) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				vic_q  <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					scan_q <= scan_q + 1'b1;
				end
				if (rd_valid_s1 && valid_s1 && (key_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
				if (rd_valid_s1 && !valid_s1) begin
					free_q <= 1'b1;
				end
				if (rd_valid_s1 && valid_s1) begin
					vic_q <= 1'b1;
				end
			end
			if (wr_en) begin
				clock_q <= clock_q + 64'd1;
			end
			if (wr_en && do_ins) begin
				valid_q[wr_slot] <= 1'b1;
				if (use_free) begin
					occ_q <= occ_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) 32'(occ_q) <= ENTRIES)
		else $error("occupancy exceeds table size");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.commit |-> !rd_valid_s1)
		else $error("commit while scan reads are in flight");
	assert property (@(posedge clk) disable iff (!arst_n) $rose(out_valid) |-> $past(cmd.load_out))
		else $error("result shown without a load");

endmodule
